// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared types and constants for the ring-store double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int ACT_W     = 3;
  localparam int STS_W     = 2;
  localparam int CNT_OUT_W = 6;
  localparam int VAL_W     = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_DROP_BACK  = 3'd2,
    ACT_DROP_FRONT = 3'd3,
    ACT_LIST       = 3'd4
  } action_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push_back;
    logic    push_front;
    logic    drop_back;
    logic    drop_front;
    logic    list_init;
    logic    list_read;
    logic    emit;
    status_t emit_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic list_done;
  } dp_sts_t;

endpackage

// ===== rtl/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Bounded double-ended queue of signed 32-bit values in a ring store.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+------------------------------------
//  input    | start && !busy            | in_action, in_value
//  result   | out_strobe, one cycle     | out_status, out_count, out_entry,
//           |                           | out_last
//
// A push or drop result shows in the cycle after the transaction is accepted,
// and a new transaction may be accepted every cycle while busy is low.
// A list holds busy while it walks the entries, one store read per cycle
// through the single read port; each result follows in the cycle after its read.
// Reset clears the front index and count; the store itself is not cleared.
// The receiver cannot stall, so results are never held back.
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [ACT_W-1:0]        in_action,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_strobe,
  output logic [STS_W-1:0]        out_status,
  output logic [CNT_OUT_W-1:0]    out_count,
  output logic signed [VAL_W-1:0] out_entry,
  output logic                    out_last
);

  cmd_t    cmd;
  dp_sts_t sts;

  deq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .value      (in_value),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_status (out_status),
    .out_count  (out_count),
    .out_entry  (out_entry),
    .out_last   (out_last)
  );

endmodule

// ===== rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Decodes each transaction and sequences the list walk.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACT_W-1:0] action,
  input  dp_sts_t          sts,
  output cmd_t             cmd,
  output logic             busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r == S_LIST);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (action_t'(action))
            ACT_PUSH_BACK: begin
              cmd.emit        = 1'b1;
              cmd.emit_status = sts.full ? ST_FULL : ST_OK;
              cmd.push_back   = !sts.full;
            end
            ACT_PUSH_FRONT: begin
              cmd.emit        = 1'b1;
              cmd.emit_status = sts.full ? ST_FULL : ST_OK;
              cmd.push_front  = !sts.full;
            end
            ACT_DROP_BACK: begin
              cmd.emit        = 1'b1;
              cmd.emit_status = sts.empty ? ST_EMPTY : ST_OK;
              cmd.drop_back   = !sts.empty;
            end
            ACT_DROP_FRONT: begin
              cmd.emit        = 1'b1;
              cmd.emit_status = sts.empty ? ST_EMPTY : ST_OK;
              cmd.drop_front  = !sts.empty;
            end
            ACT_LIST: begin
              if (sts.empty) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_EMPTY;
              end else begin
                cmd.list_init = 1'b1;
                state_nxt     = S_LIST;
              end
            end
            default: begin
              // Unknown action codes are dropped without a result.
            end
          endcase
        end
      end
      S_LIST: begin
        cmd.list_read = 1'b1;
        if (sts.list_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/deq_datapath.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring store, front index, entry count, list walk index and result registers.
// ----------------------------------------------------------------------------
module deq_datapath
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  logic signed [VAL_W-1:0] value,
  output dp_sts_t                 sts,
  output logic                    out_strobe,
  output logic [STS_W-1:0]        out_status,
  output logic [CNT_OUT_W-1:0]    out_count,
  output logic signed [VAL_W-1:0] out_entry,
  output logic                    out_last
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;

  logic signed [VAL_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r;

  logic                    strobe_r;
  logic [STS_W-1:0]        status_r;
  logic [CNT_OUT_W-1:0]    ocount_r;
  logic                    last_r;
  logic                    list_r;
  logic signed [VAL_W-1:0] rd_data_r;

  logic [SUM_W-1:0] back_sum, rd_sum;
  logic [IDX_W-1:0] back_addr, rd_addr, front_dec;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  logic [CNT_OUT_W-1:0] count_out;

  // Ring positions: the sums stay below twice the depth, so one subtract wraps.
  always_comb begin
    back_sum  = SUM_W'(front_r) + SUM_W'(count_r);
    back_addr = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                            : IDX_W'(back_sum);
    rd_sum    = SUM_W'(front_r) + SUM_W'(idx_r);
    rd_addr   = (rd_sum >= SUM_W'(DEPTH)) ? IDX_W'(rd_sum - SUM_W'(DEPTH))
                                          : IDX_W'(rd_sum);
    front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - IDX_W'(1);
  end

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = back_addr;
    priority if (cmd.push_back) begin
      wr_en     = 1'b1;
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.push_front) begin
      wr_en     = 1'b1;
      wr_addr   = front_dec;
      front_nxt = front_dec;
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.drop_back) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.drop_front) begin
      front_nxt = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + IDX_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end else begin
      front_nxt = front_r;
    end
  end

  assign sts.full      = (count_r == CNT_W'(DEPTH));
  assign sts.empty     = (count_r == '0);
  assign sts.list_done = (CNT_W'(idx_r) == count_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.list_read) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      count_r  <= '0;
      idx_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      front_r  <= front_nxt;
      count_r  <= count_nxt;
      strobe_r <= cmd.emit | cmd.list_read;
      if (cmd.list_init) begin
        idx_r <= '0;
      end else if (cmd.list_read) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // The count field keeps only its low bits; at the default depth a full store of 32 fits.
  assign count_out = CNT_OUT_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status_r <= cmd.emit_status;
      ocount_r <= count_out;
      last_r   <= 1'b1;
      list_r   <= 1'b0;
    end else if (cmd.list_read) begin
      status_r <= ST_OK;
      ocount_r <= count_out;
      last_r   <= sts.list_done;
      list_r   <= 1'b1;
    end
  end

  assign out_strobe = strobe_r;
  assign out_status = status_r;
  assign out_count  = ocount_r;
  assign out_entry  = list_r ? rd_data_r : '0;
  assign out_last   = last_r;

endmodule

// ===== rtl/deq_checker.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level assertions for the double-ended queue unit.
// ----------------------------------------------------------------------------
module deq_checker
  import deq_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic [ACT_W-1:0]        in_action,
  input logic                    out_strobe,
  input logic [STS_W-1:0]        out_status,
  input logic [CNT_OUT_W-1:0]    out_count,
  input logic signed [VAL_W-1:0] out_entry,
  input logic                    out_last
);

  // A push or drop transaction yields a final result next cycle.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action <= ACT_DROP_FRONT) |=> (out_strobe && out_last))
    else $error("push or drop did not produce a single final result");

  // Unknown action codes produce nothing.
  a_unknown_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action > ACT_LIST) |=> !out_strobe)
    else $error("unknown action produced a result");

  // An empty report carries zero count, zero entry and ends the transaction.
  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_EMPTY) |->
      (out_count == '0 && out_entry == '0 && out_last))
    else $error("empty status with inconsistent fields");

  // A list streams without gaps until its final entry.
  a_list_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> (out_strobe && out_status == ST_OK))
    else $error("list stream broke before its final entry");

  // Busy is only seen while a list walk is under way; each busy cycle has a list result following it.
  a_busy_streams: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_strobe)
    else $error("busy without a list result following");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_action  (in_action),
  .out_strobe (out_strobe),
  .out_status (out_status),
  .out_count  (out_count),
  .out_entry  (out_entry),
  .out_last   (out_last)
);
